// ===== rtl/brrc_pkg.sv =====
// brrc_pkg: shared types and codes of the broadcast ring with reader cursors
// no dependencies
package brrc_pkg;

	localparam logic [2:0] FN_ATTACH  = 3'd0;
	localparam logic [2:0] FN_DETACH  = 3'd1;
	localparam logic [2:0] FN_INSERT  = 3'd2;
	localparam logic [2:0] FN_READ    = 3'd3;
	localparam logic [2:0] FN_RESET   = 3'd4;
	localparam logic [2:0] FN_RECLAIM = 3'd5;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_DELIVERED = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_OVF_RST   = 3'd3;
	localparam logic [2:0] ST_REQ_RST   = 3'd4;
	localparam logic [2:0] ST_NO_SLOT   = 3'd5;
	localparam logic [2:0] ST_INS_RST   = 3'd6;
	localparam logic [2:0] ST_INACTIVE  = 3'd7;

	localparam logic [1:0] RC_NONE = 2'd0;
	localparam logic [1:0] RC_OVF  = 2'd1;
	localparam logic [1:0] RC_REQ  = 2'd2;

	localparam logic [0:0] CFG_LIMIT  = 1'd0;
	localparam logic [0:0] CFG_NOTICE = 1'd1;

	localparam int CNT_W = 25;

endpackage

// ===== rtl/brrc_ram.sv =====
// brrc_ram: generic single-port synchronous ram with registered read
// no dependencies
module brrc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/broadcast_ring_with_reader_cursors.sv =====
// broadcast_ring_with_reader_cursors: top level, sequencer over reader slots
// depends on brrc_pkg and brrc_ram
//
// usage: one input channel (func, reader_id, msg_data) with in_valid/in_stall,
// one result channel (status, out_reader_id, out_data, notice_flag, occupancy)
// with out_valid/out_stall. every accepted word gives exactly one result word.
// config writes via cfg_we/cfg_index/cfg_data while idle.
// per-reader state (cursor, active, reset code) sits in flip-flop rows walked
// one slot a cycle; messages sit in a single-port ram.
// detach, unused codes and empty reclaim go straight to the result; read
// waits on the ram; insert writes at once, or on a full ring first walks all
// slots to reclaim; attach walks to a free slot; reset and reclaim walk all;
// a wrap adds a shift walk. one word at a time is in work.
// the result stays in an output register; the next word is taken while a
// stalled result waits, and its result is held until the register frees.
// reset: all readers inactive, ring empty, limit 16, notice level 2867;
// ram contents are undefined until written, no clearing pass.
module broadcast_ring_with_reader_cursors #(
	parameter int QUEUE_DEPTH  = 4096,
	parameter int READERS      = 16,
	parameter int PAYLOAD_BITS = 64,
	parameter int WRAP_POINT   = 16777216
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [4:0]  reader_id,
	input  logic [63:0] msg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [4:0]  out_reader_id,
	output logic [63:0] out_data,
	output logic        notice_flag,
	output logic [12:0] occupancy,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int SW = (READERS > 1) ? $clog2(READERS) : 1;
	localparam int CW = brrc_pkg::CNT_W;
	localparam logic [CW-1:0] WRAP = CW'(WRAP_POINT);
	localparam logic [CW-1:0] QD = CW'(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_ATTACH, S_RECL, S_RECL_END, S_SHIFT,
		S_INV, S_INS_CHK, S_INS_WR, S_RD_WAIT, S_RD_DATA, S_OUT
	} state_t;

	state_t           state_q;
	logic [2:0]       func_q;
	logic [4:0]       rid_q;
	logic [PAYLOAD_BITS-1:0] data_q;
	logic [CW-1:0]    head_q, tail_q, low_q;
	logic [CW-1:0]    cursor_q [READERS];
	logic [READERS-1:0] active_q;
	logic [1:0]       rcode_q [READERS];
	logic [SW-1:0]    idx_q;
	logic [4:0]       limit_q;
	logic [12:0]      nlevel_q;
	logic             in_ins_q, notice_q;
	logic [1:0]       code_q;
	logic [2:0]       r_status_q;
	logic [4:0]       r_id_q;
	logic [63:0]      r_data_q;
	logic             r_notice_q;
	logic             ovalid_q;

	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	logic [PAYLOAD_BITS-1:0] ram_rdata;

	logic             id_ok;
	logic [SW-1:0]    slot;
	logic             last_slot;
	logic [CW-1:0]    held;
	logic [4:0]       lim;
	logic             slot_in_lim;

	assign id_ok = (rid_q >= 5'd1) && (32'(rid_q) <= READERS);
	assign slot = id_ok ? SW'(rid_q - 5'd1) : '0;
	assign last_slot = (32'(idx_q) == READERS - 1);
	assign held = head_q - tail_q;
	assign lim = (32'(limit_q) > READERS) ? 5'(READERS) : limit_q;
	assign slot_in_lim = (32'(idx_q) < 32'(lim));

	assign in_stall = (state_q != S_IDLE);
	assign ram_we = (state_q == S_INS_WR);
	assign ram_addr = (state_q == S_INS_WR) ? head_q[AW-1:0] : cursor_q[slot][AW-1:0];

	brrc_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(QUEUE_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (data_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			active_q   <= '0;
			limit_q    <= 5'd16;
			nlevel_q   <= 13'd2867;
			ovalid_q   <= 1'b0;
			idx_q      <= '0;
			for (int i = 0; i < READERS; i++) begin
				cursor_q[i] <= '0;
				rcode_q[i]  <= brrc_pkg::RC_NONE;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					brrc_pkg::CFG_LIMIT:  limit_q  <= cfg_data[4:0];
					brrc_pkg::CFG_NOTICE: nlevel_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_OUT && (!ovalid_q || !out_stall)) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q     <= func;
						rid_q      <= reader_id;
						data_q     <= msg_data[PAYLOAD_BITS-1:0];
						r_status_q <= brrc_pkg::ST_DONE;
						r_id_q     <= '0;
						r_data_q   <= '0;
						notice_q   <= 1'b0;
						in_ins_q   <= 1'b0;
						idx_q      <= '0;
						state_q    <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					unique case (func_q)
						brrc_pkg::FN_ATTACH: begin
							r_status_q <= brrc_pkg::ST_NO_SLOT;
							state_q <= S_ATTACH;
						end
						brrc_pkg::FN_DETACH: begin
							if (!id_ok || !active_q[slot]) begin
								r_status_q <= brrc_pkg::ST_INACTIVE;
							end else begin
								active_q[slot] <= 1'b0;
								cursor_q[slot] <= '0;
								rcode_q[slot]  <= brrc_pkg::RC_NONE;
							end
							state_q <= S_OUT;
						end
						brrc_pkg::FN_INSERT: begin
							if (held >= QD) begin
								in_ins_q <= 1'b1;
								low_q <= head_q;
								state_q <= S_RECL;
							end else begin
								state_q <= S_INS_WR;
							end
						end
						brrc_pkg::FN_READ: begin
							if (!id_ok || !active_q[slot]) begin
								r_status_q <= brrc_pkg::ST_INACTIVE;
								state_q <= S_OUT;
							end else if (rcode_q[slot] == brrc_pkg::RC_OVF ||
									rcode_q[slot] == brrc_pkg::RC_REQ) begin
								r_status_q <= (rcode_q[slot] == brrc_pkg::RC_OVF) ?
									brrc_pkg::ST_OVF_RST : brrc_pkg::ST_REQ_RST;
								rcode_q[slot]  <= brrc_pkg::RC_NONE;
								cursor_q[slot] <= head_q;
								state_q <= S_OUT;
							end else if (cursor_q[slot] >= head_q) begin
								r_status_q <= brrc_pkg::ST_EMPTY;
								state_q <= S_OUT;
							end else begin
								state_q <= S_RD_WAIT;
							end
						end
						brrc_pkg::FN_RESET: begin
							code_q <= brrc_pkg::RC_REQ;
							head_q <= '0;
							tail_q <= '0;
							state_q <= S_INV;
						end
						brrc_pkg::FN_RECLAIM: begin
							low_q <= head_q;
							state_q <= (head_q == tail_q) ? S_OUT : S_RECL;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_ATTACH: begin
					if (slot_in_lim && !active_q[idx_q]) begin
						active_q[idx_q] <= 1'b1;
						cursor_q[idx_q] <= head_q;
						rcode_q[idx_q]  <= brrc_pkg::RC_NONE;
						r_id_q     <= 5'(idx_q) + 5'd1;
						r_status_q <= brrc_pkg::ST_DONE;
						state_q <= S_OUT;
					end else if (last_slot) begin
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_RECL: begin
					if (active_q[idx_q] && cursor_q[idx_q] < low_q) begin
						low_q <= cursor_q[idx_q];
					end
					if (last_slot) begin
						state_q <= S_RECL_END;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_RECL_END: begin
					notice_q <= (held == CW'(nlevel_q));
					idx_q <= '0;
					if (low_q >= WRAP) begin
						tail_q <= low_q - WRAP;
						head_q <= head_q - WRAP;
						state_q <= S_SHIFT;
					end else begin
						tail_q <= low_q;
						state_q <= in_ins_q ? S_INS_CHK : S_OUT;
					end
				end
				S_SHIFT: begin
					if (active_q[idx_q]) begin
						cursor_q[idx_q] <= cursor_q[idx_q] - WRAP;
					end
					if (last_slot) begin
						idx_q <= '0;
						state_q <= in_ins_q ? S_INS_CHK : S_OUT;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_INS_CHK: begin
					if (held >= QD) begin
						code_q <= brrc_pkg::RC_OVF;
						head_q <= '0;
						tail_q <= '0;
						r_status_q <= brrc_pkg::ST_INS_RST;
						idx_q <= '0;
						state_q <= S_INV;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					head_q <= head_q + CW'(1);
					state_q <= S_OUT;
				end
				S_INV: begin
					if (active_q[idx_q]) begin
						if (rcode_q[idx_q] == brrc_pkg::RC_NONE || code_q < rcode_q[idx_q]) begin
							rcode_q[idx_q] <= code_q;
						end
						cursor_q[idx_q] <= '0;
					end
					if (last_slot) begin
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_RD_WAIT: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					r_data_q <= 64'(ram_rdata);
					cursor_q[slot] <= cursor_q[slot] + CW'(1);
					r_status_q <= brrc_pkg::ST_DELIVERED;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ovalid_q || !out_stall) begin
						status        <= r_status_q;
						out_reader_id <= r_id_q;
						out_data      <= r_data_q;
						notice_flag   <= notice_q;
						occupancy     <= held[12:0];
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign r_notice_q = notice_q;

	a_tail_le_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> tail_q <= head_q)
		else $error("tail passed head");
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> held <= QD)
		else $error("occupancy above depth");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall)
		else $error("accepting while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(occupancy))
		else $error("stalled result changed");
	a_notice_used: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && r_notice_q |-> func_q == brrc_pkg::FN_RECLAIM ||
			func_q == brrc_pkg::FN_INSERT)
		else $error("notice without reclaim");

endmodule
